[sv/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, op and status codes, beat types and the control
// structs for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] push_value;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      read_value;
        logic             is_empty;
        logic             is_full;
        logic [CNT_W-1:0] fill_level;
    } res_beat_t;

    // Memory request from the pointer logic
    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
    } mem_req_t;

    // Everything of a result except the entry read from memory
    typedef struct packed {
        logic [1:0]       status;
        logic             rd_used;
        logic             is_empty;
        logic             is_full;
        logic [CNT_W-1:0] fill_level;
    } res_info_t;

endpackage

[sv/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int DEPTH = bdq_pkg::DEPTH,
    parameter int WIDTH = bdq_pkg::DATA_WIDTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl
// Front and back pointers and the entry count. Decodes one command,
// checks it against full and empty, and issues the memory access.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  bdq_pkg::cmd_beat_t  cmd,
    output bdq_pkg::mem_req_t   mem_req,
    output bdq_pkg::res_info_t  info
);

    localparam logic [bdq_pkg::ADDR_W-1:0] LAST_IDX =
        bdq_pkg::ADDR_W'(bdq_pkg::DEPTH - 1);
    localparam logic [bdq_pkg::CNT_W-1:0] FULL_CNT =
        bdq_pkg::CNT_W'(bdq_pkg::DEPTH);

    logic [bdq_pkg::ADDR_W-1:0] front_reg, front_next;
    logic [bdq_pkg::ADDR_W-1:0] back_reg, back_next;
    logic [bdq_pkg::CNT_W-1:0]  count_reg, count_next;

    logic [bdq_pkg::ADDR_W-1:0] front_up, front_dn, back_up, back_dn;
    logic                       full, empty, is_push, is_read;
    logic                       do_wr, do_rd;
    logic [bdq_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [1:0]                 status;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    // Wrap at DEPTH, which need not be a power of two
    assign front_up = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dn = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign back_up  = (back_reg == LAST_IDX) ? '0 : back_reg + 1'b1;
    assign back_dn  = (back_reg == '0) ? LAST_IDX : back_reg - 1'b1;

    assign is_push = (cmd.op == bdq_pkg::OP_PUSH_FRONT) ||
                     (cmd.op == bdq_pkg::OP_PUSH_BACK);
    assign is_read = (cmd.op == bdq_pkg::OP_POP_FRONT)  ||
                     (cmd.op == bdq_pkg::OP_POP_BACK)   ||
                     (cmd.op == bdq_pkg::OP_PEEK_FRONT) ||
                     (cmd.op == bdq_pkg::OP_PEEK_BACK);

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        do_wr      = 1'b0;
        do_rd      = 1'b0;
        wr_addr    = front_dn;
        rd_addr    = front_reg;
        status     = bdq_pkg::ST_DONE;

        if (is_push && full)
        begin
            status = bdq_pkg::ST_FULL;
        end
        else if (is_read && empty)
        begin
            status = bdq_pkg::ST_EMPTY;
        end
        else
        begin
            case (cmd.op)
                bdq_pkg::OP_PUSH_FRONT:
                begin
                    front_next = front_dn;
                    wr_addr    = front_dn;
                    do_wr      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                bdq_pkg::OP_PUSH_BACK:
                begin
                    back_next  = back_up;
                    wr_addr    = back_up;
                    do_wr      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                bdq_pkg::OP_POP_FRONT:
                begin
                    rd_addr    = front_reg;
                    do_rd      = 1'b1;
                    front_next = front_up;
                    count_next = count_reg - 1'b1;
                end
                bdq_pkg::OP_POP_BACK:
                begin
                    rd_addr    = back_reg;
                    do_rd      = 1'b1;
                    back_next  = back_dn;
                    count_next = count_reg - 1'b1;
                end
                bdq_pkg::OP_PEEK_FRONT:
                begin
                    rd_addr = front_reg;
                    do_rd   = 1'b1;
                end
                bdq_pkg::OP_PEEK_BACK:
                begin
                    rd_addr = back_reg;
                    do_rd   = 1'b1;
                end
                default:
                begin
                    // unused codes leave the state alone
                end
            endcase
        end
    end

    always_comb
    begin
        mem_req.wr_en   = go && do_wr;
        mem_req.wr_addr = wr_addr;
        mem_req.wr_data = cmd.push_value[bdq_pkg::DATA_WIDTH-1:0];
        mem_req.rd_en   = go && do_rd;
        mem_req.rd_addr = rd_addr;

        info.status     = status;
        info.rd_used    = do_rd;
        info.is_empty   = (count_next == '0);
        info.is_full    = (count_next == FULL_CNT);
        info.fill_level = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= LAST_IDX;
            count_reg <= '0;
        end
        else if (go)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

endmodule

[sv/bounded_double_ended_queue.sv]
// A result passes the pending stage, beside the registered RAM read data, and
// then the result register. Throughput: one command per cycle while results
// drain. Reset sets the front pointer and count to zero and the back pointer
// to the last index at once; the entry RAM is not cleared and needs no
// clearing pass, so commands are taken right after reset.
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque over a circular buffer in a synchronous RAM. Each command
// beat pushes, pops or peeks at either end and yields one result beat.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  bdq_pkg::cmd_beat_t cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output bdq_pkg::res_beat_t res
);

    bdq_pkg::mem_req_t  mem_req;
    bdq_pkg::res_info_t info;
    logic [bdq_pkg::DATA_WIDTH-1:0] rd_data;

    // Stage between the RAM read and the result register: waits for read data
    logic               pend_valid_reg, pend_valid_next;
    bdq_pkg::res_info_t pend_info_reg;

    logic               res_valid_reg, res_valid_next;
    bdq_pkg::res_beat_t res_data_reg;

    logic accept;
    logic advance;

    // Pointers, count and the memory request for the command in flight
    bdq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (accept),
        .cmd     (cmd),
        .mem_req (mem_req),
        .info    (info)
    );

    bdq_ram #(
        .DEPTH (bdq_pkg::DEPTH),
        .WIDTH (bdq_pkg::DATA_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    // Advance the pending beat into the result register when that slot is
    // empty or being taken this cycle.
    assign advance = pend_valid_reg && (!res_valid_reg || !res_stall);

    // Hold commands only while the pending beat cannot move on. A new read
    // issued in the same cycle lands in the RAM output register at the same
    // edge that the old read data is captured into the result, so no overlap.
    assign cmd_stall = pend_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (advance)
        begin
            pend_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers: capture the decode on accept, merge read data on advance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_info_reg <= info;
        end
        if (advance)
        begin
            res_data_reg.status     <= pend_info_reg.status;
            res_data_reg.read_value <= pend_info_reg.rd_used ? 32'(rd_data) : '0;
            res_data_reg.is_empty   <= pend_info_reg.is_empty;
            res_data_reg.is_full    <= pend_info_reg.is_full;
            res_data_reg.fill_level <= pend_info_reg.fill_level;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_data_reg;

    // A pending beat blocked by a stalled result must hold off new commands
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && res_valid_reg && res_stall) |-> cmd_stall)
        else $error("command taken while pending beat is blocked");

    // Every accepted command reaches the pending stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_valid_reg)
        else $error("accepted command lost before the read stage");

    // Rejected operations return no data
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_data_reg.status != bdq_pkg::ST_DONE))
        |-> (res_data_reg.read_value == '0))
        else $error("rejected operation returned data");

    // A full rejection can only be reported while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_data_reg.status == bdq_pkg::ST_FULL))
        |-> res_data_reg.is_full)
        else $error("full rejection with queue not full");

endmodule
